>>> hw/rtl/mrrb_pkg.sv
// Shared constants, types and helper functions of the multi-reader ring buffer.
package mrrb_pkg;

    // Store geometry and reader count.
    localparam int DEPTH       = 512;
    localparam int CONSUMERS   = 8;
    localparam int SAMPLE_BITS = 32;

    // Only eight reader slots can be addressed by the reader field.
    localparam int SLOTS = (CONSUMERS < 8) ? CONSUMERS : 8;

    // Derived widths: store position, count up to DEPTH, slot index.
    localparam int PW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam int SW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int MW = (CW > 10) ? CW : 10;

    // Field widths of the request and result channels.
    localparam int KIND_W   = 3;
    localparam int SAMPLE_W = 32;
    localparam int READER_W = 3;
    localparam int AMOUNT_W = 10;
    localparam int COUNT_W  = 10;
    localparam int STATUS_W = 3;

    // Request kinds.
    localparam logic [KIND_W-1:0] K_PUSH   = 3'd0;
    localparam logic [KIND_W-1:0] K_READ   = 3'd1;
    localparam logic [KIND_W-1:0] K_PEEK   = 3'd2;
    localparam logic [KIND_W-1:0] K_SKIP   = 3'd3;
    localparam logic [KIND_W-1:0] K_ATTACH = 3'd4;
    localparam logic [KIND_W-1:0] K_DETACH = 3'd5;

    // Result status codes.
    localparam logic [STATUS_W-1:0] ST_OK       = 3'd0;
    localparam logic [STATUS_W-1:0] ST_FULL     = 3'd1;
    localparam logic [STATUS_W-1:0] ST_EMPTY    = 3'd2;
    localparam logic [STATUS_W-1:0] ST_NO_SLOT  = 3'd3;
    localparam logic [STATUS_W-1:0] ST_DETACHED = 3'd4;

    typedef logic [PW-1:0] t_pos;
    typedef logic [CW-1:0] t_count;

    // Samples a reader can still take. Equal positions with data pending
    // mean the reader is a whole store behind the writer.
    function automatic t_count pend_count(t_pos wp, t_pos rp, logic has);
        if (!has) begin
            return '0;
        end
        if (wp > rp) begin
            return CW'(wp) - CW'(rp);
        end
        return CW'(DEPTH) - CW'(rp) + CW'(wp);
    endfunction

endpackage

>>> hw/rtl/mrrb_if.sv
// Request and result channel interfaces of the multi-reader ring buffer.
interface mrrb_req_if;
    logic                           valid;
    logic                           ready;
    logic [mrrb_pkg::KIND_W-1:0]    kind;
    logic [mrrb_pkg::SAMPLE_W-1:0]  sample;
    logic [mrrb_pkg::READER_W-1:0]  reader;
    logic [mrrb_pkg::AMOUNT_W-1:0]  amount;

    modport source (output valid, kind, sample, reader, amount, input ready);
    modport sink   (input valid, kind, sample, reader, amount, output ready);
endinterface

interface mrrb_rsp_if;
    logic                           valid;
    logic                           ready;
    logic [mrrb_pkg::SAMPLE_W-1:0]  data_word;
    logic [mrrb_pkg::COUNT_W-1:0]   done_count;
    logic [mrrb_pkg::READER_W-1:0]  granted_reader;
    logic [mrrb_pkg::COUNT_W-1:0]   pending;
    logic [mrrb_pkg::COUNT_W-1:0]   fill;
    logic [mrrb_pkg::STATUS_W-1:0]  status;

    modport source (output valid, data_word, done_count, granted_reader, pending, fill,
                     status, input ready);
    modport sink   (input valid, data_word, done_count, granted_reader, pending, fill,
                    status, output ready);
endinterface

>>> hw/rtl/mrrb_ram.sv
// Generic single-write, single-read RAM with a registered read port.
module mrrb_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 512
) (
    input  logic                                         i_clk,
    input  logic                                         i_wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]                             i_wr_data,
    input  logic                                         i_rd_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]                             o_rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    // Write port and registered read port; read data holds between reads.
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

>>> hw/rtl/multi_reader_ring_buffer.sv
// Top level of the multi-reader ring buffer: control sequencer around two RAMs.
//
// One writer pushes samples into a circular store; up to eight reader slots each
// keep a read position and may read, peek at an offset, skip, attach or detach.
// Every request gives exactly one result. A request passes through accept, execute
// against the read-position RAM and loading of the result register; when the fill
// level must be recomputed (every detach, and a read or skip by the reader that
// set the fill) the sequencer scans all slots through the single read port of the
// read-position RAM before the result register is loaded.
// A new request is taken while the previous result still waits in the output
// register. The sample RAM needs no clearing after reset.
module multi_reader_ring_buffer (
    input  logic       i_clk,
    input  logic       i_rst_n,
    mrrb_req_if.sink   i_req,
    mrrb_rsp_if.source o_rsp
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_SCAN,
        S_SCAN_LAST,
        S_RESULT
    } t_state;

    t_state r_state;

    // Latched request.
    logic [mrrb_pkg::KIND_W-1:0]   r_kind;
    logic [mrrb_pkg::SAMPLE_W-1:0] r_sample;
    logic [mrrb_pkg::READER_W-1:0] r_reader;
    logic [mrrb_pkg::AMOUNT_W-1:0] r_amount;
    logic                          r_rd_ok;

    // Buffer state kept in flip-flops.
    mrrb_pkg::t_pos                r_wp;
    mrrb_pkg::t_count              r_fill;
    logic [mrrb_pkg::SLOTS-1:0]    r_attached;
    logic [mrrb_pkg::SLOTS-1:0]    r_has;

    // Working registers of the current request.
    mrrb_pkg::t_pos                r_rp;
    logic [mrrb_pkg::SW-1:0]       r_addr;
    logic                          r_addr_ok;
    logic                          r_use_data;
    mrrb_pkg::t_count              r_done;
    logic [mrrb_pkg::READER_W-1:0] r_granted;
    logic [mrrb_pkg::STATUS_W-1:0] r_status;

    // Next values of the working registers, decided in the execute cycle.
    mrrb_pkg::t_pos                n_rp;
    logic [mrrb_pkg::SW-1:0]       n_addr;
    logic                          n_addr_ok;
    logic                          n_use_data;
    mrrb_pkg::t_count              n_done;
    logic [mrrb_pkg::READER_W-1:0] n_granted;
    logic [mrrb_pkg::STATUS_W-1:0] n_status;
    logic                          n_scan;

    // Fill recompute scan.
    logic [mrrb_pkg::SW-1:0]       r_scan;
    logic                          r_cmp_vld;
    logic [mrrb_pkg::SW-1:0]       r_cmp_idx;
    mrrb_pkg::t_count              r_best;

    // Output register.
    logic                          r_out_valid;
    logic [mrrb_pkg::SAMPLE_W-1:0] r_out_data;
    logic [mrrb_pkg::COUNT_W-1:0]  r_out_done;
    logic [mrrb_pkg::READER_W-1:0] r_out_granted;
    logic [mrrb_pkg::COUNT_W-1:0]  r_out_pending;
    logic [mrrb_pkg::COUNT_W-1:0]  r_out_fill;
    logic [mrrb_pkg::STATUS_W-1:0] r_out_status;
    logic                          out_load;

    // RAM ports.
    logic                             smp_wr_en;
    logic                             smp_rd_en;
    mrrb_pkg::t_pos                   smp_rd_addr;
    logic [mrrb_pkg::SAMPLE_BITS-1:0] smp_rd_data;
    logic                             pos_wr_en;
    logic [mrrb_pkg::SW-1:0]          pos_wr_addr;
    mrrb_pkg::t_pos                   pos_wr_data;
    logic                             pos_rd_en;
    logic [mrrb_pkg::SW-1:0]          pos_rd_addr;
    mrrb_pkg::t_pos                   pos_rd_data;

    // Execute-stage decode.
    logic                    req_take;
    logic [mrrb_pkg::SW-1:0] idx;
    logic                    att;
    mrrb_pkg::t_count        pend;
    mrrb_pkg::t_count        skip_n;
    mrrb_pkg::t_count        adv_n;
    logic [mrrb_pkg::CW:0]   adv_sum;
    mrrb_pkg::t_pos          adv_pos;
    logic [mrrb_pkg::MW:0]   peek_sum;
    mrrb_pkg::t_pos          peek_addr;
    logic                    peek_ok;
    logic                    free_found;
    logic [mrrb_pkg::SW-1:0] free_idx;
    logic                    do_advance;
    logic                    do_attach;
    mrrb_pkg::t_count        pend_cmp;
    mrrb_pkg::t_count        pend_out;
    mrrb_pkg::t_pos          wp_inc;

    assign req_take = i_req.valid && i_req.ready;
    assign i_req.ready = (r_state == S_IDLE);

    // Addressed reader and its pending count, from the position just read.
    assign idx  = r_reader[mrrb_pkg::SW-1:0];
    assign att  = r_rd_ok && r_attached[idx];
    assign pend = mrrb_pkg::pend_count(r_wp, pos_rd_data, att && r_has[idx]);

    // Skip amount clamped to the pending count.
    assign skip_n = (mrrb_pkg::MW'(r_amount) < mrrb_pkg::MW'(pend)) ?
                    mrrb_pkg::CW'(r_amount) : pend;
    assign adv_n  = (r_kind == mrrb_pkg::K_READ) ? mrrb_pkg::CW'(1) : skip_n;

    // New read position after an advance, wrapped once.
    always_comb begin
        adv_sum = (mrrb_pkg::CW + 1)'(pos_rd_data) + (mrrb_pkg::CW + 1)'(adv_n);
        if (adv_sum >= (mrrb_pkg::CW + 1)'(mrrb_pkg::DEPTH)) begin
            adv_pos = mrrb_pkg::PW'(adv_sum - (mrrb_pkg::CW + 1)'(mrrb_pkg::DEPTH));
        end else begin
            adv_pos = mrrb_pkg::PW'(adv_sum);
        end
    end

    // Peek address; the offset is below the pending count when it is used.
    always_comb begin
        peek_sum = (mrrb_pkg::MW + 1)'(pos_rd_data) + (mrrb_pkg::MW + 1)'(r_amount);
        if (peek_sum >= (mrrb_pkg::MW + 1)'(mrrb_pkg::DEPTH)) begin
            peek_addr = mrrb_pkg::PW'(peek_sum - (mrrb_pkg::MW + 1)'(mrrb_pkg::DEPTH));
        end else begin
            peek_addr = mrrb_pkg::PW'(peek_sum);
        end
    end
    assign peek_ok = mrrb_pkg::MW'(r_amount) < mrrb_pkg::MW'(pend);

    // Lowest free reader slot.
    always_comb begin
        free_found = 1'b0;
        free_idx   = '0;
        for (int i = mrrb_pkg::SLOTS - 1; i >= 0; i--) begin
            if (!r_attached[i]) begin
                free_found = 1'b1;
                free_idx   = mrrb_pkg::SW'(i);
            end
        end
    end

    // Read or a nonzero skip by an attached reader with data moves its position.
    assign do_advance = (r_state == S_EXEC) && att && (pend != '0) &&
                        ((r_kind == mrrb_pkg::K_READ) ||
                         ((r_kind == mrrb_pkg::K_SKIP) && (skip_n != '0)));
    assign do_attach  = (r_state == S_EXEC) && (r_kind == mrrb_pkg::K_ATTACH) && free_found;

    assign wp_inc = (r_wp == mrrb_pkg::PW'(mrrb_pkg::DEPTH - 1)) ? '0 : r_wp + 1'b1;

    // Result fields of the request and whether the fill must be rescanned.
    always_comb begin
        n_use_data = 1'b0;
        n_done     = '0;
        n_granted  = '0;
        n_status   = mrrb_pkg::ST_OK;
        n_rp       = pos_rd_data;
        n_addr     = idx;
        n_addr_ok  = r_rd_ok;
        n_scan     = 1'b0;

        unique case (r_kind)
            mrrb_pkg::K_PUSH: begin
                if (r_fill >= mrrb_pkg::CW'(mrrb_pkg::DEPTH)) begin
                    n_status = mrrb_pkg::ST_FULL;
                end else begin
                    n_done = mrrb_pkg::CW'(1);
                end
            end

            mrrb_pkg::K_READ, mrrb_pkg::K_PEEK, mrrb_pkg::K_SKIP: begin
                if (!att) begin
                    n_status = mrrb_pkg::ST_DETACHED;
                end else if (pend == '0) begin
                    n_status = mrrb_pkg::ST_EMPTY;
                end else if (r_kind == mrrb_pkg::K_PEEK) begin
                    if (peek_ok) begin
                        n_use_data = 1'b1;
                    end else begin
                        n_status = mrrb_pkg::ST_EMPTY;
                    end
                end else begin
                    n_use_data = (r_kind == mrrb_pkg::K_READ);
                    n_done     = adv_n;
                    if (do_advance) begin
                        n_rp = adv_pos;
                        // The slowest reader moved: find the new fill.
                        n_scan = (pend == r_fill);
                    end
                end
            end

            mrrb_pkg::K_ATTACH: begin
                if (!free_found) begin
                    n_status  = mrrb_pkg::ST_NO_SLOT;
                    n_addr_ok = 1'b0;
                end else begin
                    n_rp      = r_wp;
                    n_addr    = free_idx;
                    n_addr_ok = 1'b1;
                    n_granted = mrrb_pkg::READER_W'(free_idx);
                end
            end

            mrrb_pkg::K_DETACH: begin
                if (!att) begin
                    n_status = mrrb_pkg::ST_DETACHED;
                end
                n_scan = 1'b1;
            end

            default: begin
            end
        endcase
    end

    // Pending counts for the fill scan and for the result.
    assign pend_cmp = mrrb_pkg::pend_count(r_wp, pos_rd_data,
                                           r_attached[r_cmp_idx] && r_has[r_cmp_idx]);
    assign pend_out = mrrb_pkg::pend_count(r_wp, r_rp,
                                           r_addr_ok && r_attached[r_addr] && r_has[r_addr]);

    // The result register loads when it is empty or being emptied.
    assign out_load = (r_state == S_RESULT) && (!r_out_valid || o_rsp.ready);

    // Sample RAM control: push writes, read and peek fetch in the execute cycle.
    assign smp_wr_en   = (r_state == S_EXEC) && (r_kind == mrrb_pkg::K_PUSH) &&
                         (r_fill < mrrb_pkg::CW'(mrrb_pkg::DEPTH));
    assign smp_rd_en   = (r_state == S_EXEC);
    assign smp_rd_addr = (r_kind == mrrb_pkg::K_PEEK) ? peek_addr : pos_rd_data;

    // Read-position RAM control.
    always_comb begin
        pos_rd_en   = req_take || (r_state == S_SCAN);
        pos_rd_addr = (r_state == S_SCAN) ? r_scan : i_req.reader[mrrb_pkg::SW-1:0];
        pos_wr_en   = do_advance || do_attach;
        pos_wr_addr = do_attach ? free_idx : idx;
        pos_wr_data = do_attach ? r_wp : adv_pos;
    end

    mrrb_ram #(
        .WIDTH (mrrb_pkg::SAMPLE_BITS),
        .DEPTH (mrrb_pkg::DEPTH)
    ) u_sample_ram (
        .i_clk     (i_clk),
        .i_wr_en   (smp_wr_en),
        .i_wr_addr (r_wp),
        .i_wr_data (mrrb_pkg::SAMPLE_BITS'(r_sample)),
        .i_rd_en   (smp_rd_en),
        .i_rd_addr (smp_rd_addr),
        .o_rd_data (smp_rd_data)
    );

    mrrb_ram #(
        .WIDTH (mrrb_pkg::PW),
        .DEPTH (mrrb_pkg::SLOTS)
    ) u_pos_ram (
        .i_clk     (i_clk),
        .i_wr_en   (pos_wr_en),
        .i_wr_addr (pos_wr_addr),
        .i_wr_data (pos_wr_data),
        .i_rd_en   (pos_rd_en),
        .i_rd_addr (pos_rd_addr),
        .o_rd_data (pos_rd_data)
    );

    // Sequencer, buffer state and output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_wp        <= '0;
            r_fill      <= '0;
            r_attached  <= '0;
            r_has       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (o_rsp.valid && o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (req_take) begin
                        r_kind   <= i_req.kind;
                        r_sample <= i_req.sample;
                        r_reader <= i_req.reader;
                        r_amount <= i_req.amount;
                        r_rd_ok  <= ({1'b0, i_req.reader} < 4'(mrrb_pkg::SLOTS));
                        r_state  <= S_EXEC;
                    end
                end

                S_EXEC: begin
                    r_use_data <= n_use_data;
                    r_done     <= n_done;
                    r_granted  <= n_granted;
                    r_status   <= n_status;
                    r_rp       <= n_rp;
                    r_addr     <= n_addr;
                    r_addr_ok  <= n_addr_ok;
                    r_scan     <= '0;
                    r_cmp_vld  <= 1'b0;
                    r_best     <= '0;
                    r_state    <= n_scan ? S_SCAN : S_RESULT;

                    unique case (r_kind)
                        mrrb_pkg::K_PUSH: begin
                            if (r_fill < mrrb_pkg::CW'(mrrb_pkg::DEPTH)) begin
                                r_wp   <= wp_inc;
                                r_has  <= r_has | r_attached;
                                r_fill <= r_fill + 1'b1;
                            end
                        end

                        mrrb_pkg::K_READ, mrrb_pkg::K_PEEK, mrrb_pkg::K_SKIP: begin
                            // A reader that caught up with the writer has nothing left.
                            if (do_advance && (adv_pos == r_wp)) begin
                                r_has[idx] <= 1'b0;
                            end
                        end

                        mrrb_pkg::K_ATTACH: begin
                            if (free_found) begin
                                r_attached[free_idx] <= 1'b1;
                                r_has[free_idx]      <= 1'b0;
                            end
                        end

                        mrrb_pkg::K_DETACH: begin
                            if (att) begin
                                r_attached[idx] <= 1'b0;
                                r_has[idx]      <= 1'b0;
                            end
                        end

                        default: begin
                        end
                    endcase
                end

                // One slot read per cycle; each compare falls in the cycle after its read.
                S_SCAN: begin
                    r_cmp_vld <= 1'b1;
                    r_cmp_idx <= r_scan;
                    if (r_cmp_vld && (pend_cmp > r_best)) begin
                        r_best <= pend_cmp;
                    end
                    if (r_scan == mrrb_pkg::SW'(mrrb_pkg::SLOTS - 1)) begin
                        r_state <= S_SCAN_LAST;
                    end else begin
                        r_scan <= r_scan + 1'b1;
                    end
                end

                S_SCAN_LAST: begin
                    r_fill  <= (pend_cmp > r_best) ? pend_cmp : r_best;
                    r_state <= S_RESULT;
                end

                S_RESULT: begin
                    if (out_load) begin
                        r_out_data    <= r_use_data ? mrrb_pkg::SAMPLE_W'(smp_rd_data) : '0;
                        r_out_done    <= mrrb_pkg::COUNT_W'(r_done);
                        r_out_granted <= r_granted;
                        r_out_pending <= mrrb_pkg::COUNT_W'(pend_out);
                        r_out_fill    <= mrrb_pkg::COUNT_W'(r_fill);
                        r_out_status  <= r_status;
                        r_state       <= S_IDLE;
                    end
                end

                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_rsp.valid          = r_out_valid;
    assign o_rsp.data_word      = r_out_data;
    assign o_rsp.done_count     = r_out_done;
    assign o_rsp.granted_reader = r_out_granted;
    assign o_rsp.pending        = r_out_pending;
    assign o_rsp.fill           = r_out_fill;
    assign o_rsp.status         = r_out_status;

endmodule
